FILE: rtl/tsl_pkg.sv
// Shared widths, register indexes and reset values for the tachometer shift light.
`default_nettype none

package tsl_pkg;

  // Field widths
  localparam int unsigned SCALE_W    = 10;  // rpm_per_spark
  localparam int unsigned RPM_W      = 16;  // rpm, interval and thresholds
  localparam int unsigned LED_N      = 4;   // LEDs on the bar graph
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Default spark counter width
  localparam int unsigned SPARK_COUNT_BITS_DFLT = 10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RPM_PER_SPARK   = 3'd0,
    CFG_UPDATE_INTERVAL = 3'd1,
    CFG_LED0_THRESHOLD  = 3'd2,
    CFG_LED1_THRESHOLD  = 3'd3,
    CFG_LED2_THRESHOLD  = 3'd4,
    CFG_LED3_THRESHOLD  = 3'd5,
    CFG_LIMITER_THRESH  = 3'd6
  } cfg_idx_e;

  // Register reset values
  localparam logic [SCALE_W-1:0] RST_RPM_PER_SPARK   = 10'd150;
  localparam logic [RPM_W-1:0]   RST_UPDATE_INTERVAL = 16'd200;
  localparam logic [RPM_W-1:0]   RST_LED0_THRESHOLD  = 16'd4000;
  localparam logic [RPM_W-1:0]   RST_LED1_THRESHOLD  = 16'd4500;
  localparam logic [RPM_W-1:0]   RST_LED2_THRESHOLD  = 16'd5000;
  localparam logic [RPM_W-1:0]   RST_LED3_THRESHOLD  = 16'd5500;
  localparam logic [RPM_W-1:0]   RST_LIMITER_THRESH  = 16'd5800;

endpackage

`default_nettype wire

FILE: rtl/tsl_if.sv
// Handshake channel interfaces: input items, result items and configuration writes.
`default_nettype none

interface tsl_in_if;
  logic valid;
  logic ready;
  logic ms_tick;
  logic spark_fire;

  modport source (output valid, output ms_tick, output spark_fire, input ready);
  modport sink   (input valid, input ms_tick, input spark_fire, output ready);
endinterface

interface tsl_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [tsl_pkg::LED_N-1:0]              led_pattern;
  logic [tsl_pkg::RPM_W-1:0]              rpm_averaged;
  logic                                   limiter_active;

  modport source (output valid, output led_pattern, output rpm_averaged,
                  output limiter_active, input ready);
  modport sink   (input valid, input led_pattern, input rpm_averaged,
                  input limiter_active, output ready);
endinterface

interface tsl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tsl_pkg::CFG_IDX_W-1:0]   index;
  logic [tsl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tachometer_shift_light_top.sv
// Tachometer shift light: spark counting, interval timing and the LED bar graph.
`default_nettype none

// Each input transaction carries a millisecond tick and a spark edge flag; one
// is taken every cycle while the result side keeps up. Sparks are counted
// (saturating at the counter's maximum) and ticks advance an elapsed counter.
// The tick that takes the counter past update_interval_ms closes the interval
// (a spark in that same transaction still counts) and yields one result
// transaction; all other input transactions yield none. A result reaches out_o
// through the product register and then the output register. The product register
// takes spark_count * rpm_per_spark; the output stage then saturates it
// to 16 bits, averages it with the previous raw rpm and runs the threshold
// compares into the output register. Above limiter_threshold all four LEDs
// blink together, lit on the first such update; otherwise LED i lights when
// the average exceeds its threshold. in_i.ready falls only while both the
// product register and the output register hold results waiting on out_o.
// Configuration writes are always taken and must be made while the block is
// idle; indexes beyond the register list are ignored.

module tachometer_shift_light_top #(
  parameter int unsigned SPARK_COUNT_BITS = tsl_pkg::SPARK_COUNT_BITS_DFLT
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tsl_in_if.sink      in_i,
  tsl_out_if.source   out_o,
  tsl_cfg_if.sink     cfg_i
);

  localparam int unsigned PROD_W = SPARK_COUNT_BITS + tsl_pkg::SCALE_W;
  localparam int unsigned RPM_W  = tsl_pkg::RPM_W;
  localparam int unsigned LED_N  = tsl_pkg::LED_N;
  localparam logic [SPARK_COUNT_BITS-1:0] SparkMax = {SPARK_COUNT_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [tsl_pkg::SCALE_W-1:0] scale_q;
  logic [RPM_W-1:0]            interval_q;
  logic [RPM_W-1:0]            led_thr_q [LED_N];
  logic [RPM_W-1:0]            limit_thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q      <= tsl_pkg::RST_RPM_PER_SPARK;
      interval_q   <= tsl_pkg::RST_UPDATE_INTERVAL;
      led_thr_q[0] <= tsl_pkg::RST_LED0_THRESHOLD;
      led_thr_q[1] <= tsl_pkg::RST_LED1_THRESHOLD;
      led_thr_q[2] <= tsl_pkg::RST_LED2_THRESHOLD;
      led_thr_q[3] <= tsl_pkg::RST_LED3_THRESHOLD;
      limit_thr_q  <= tsl_pkg::RST_LIMITER_THRESH;
    end else if (cfg_i.valid) begin
      case (tsl_pkg::cfg_idx_e'(cfg_i.index))
        tsl_pkg::CFG_RPM_PER_SPARK:   scale_q      <= cfg_i.data[tsl_pkg::SCALE_W-1:0];
        tsl_pkg::CFG_UPDATE_INTERVAL: interval_q   <= cfg_i.data;
        tsl_pkg::CFG_LED0_THRESHOLD:  led_thr_q[0] <= cfg_i.data;
        tsl_pkg::CFG_LED1_THRESHOLD:  led_thr_q[1] <= cfg_i.data;
        tsl_pkg::CFG_LED2_THRESHOLD:  led_thr_q[2] <= cfg_i.data;
        tsl_pkg::CFG_LED3_THRESHOLD:  led_thr_q[3] <= cfg_i.data;
        tsl_pkg::CFG_LIMITER_THRESH:  limit_thr_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: product stage and output register
  // ---------------------------------------------------------------------------
  logic prod_vld_q;
  logic out_vld_q;
  logic out_take;   // output register can load this cycle
  logic prod_move;  // product stage hands over to the output register
  logic in_acc;

  assign out_take   = !out_vld_q || out_o.ready;
  assign prod_move  = prod_vld_q && out_take;
  assign in_i.ready = !prod_vld_q || out_take;
  assign in_acc     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Stage 1: spark count, elapsed time, product
  // ---------------------------------------------------------------------------
  logic [SPARK_COUNT_BITS-1:0] spark_cnt_q, spark_cnt_d, spark_upd;
  logic [RPM_W-1:0]            elapsed_q, elapsed_d;
  logic [RPM_W:0]              elapsed_inc;
  logic                        close_int;
  logic [PROD_W-1:0]           prod_q;

  always_comb begin
    spark_upd = spark_cnt_q;
    if (in_i.spark_fire && (spark_cnt_q != SparkMax)) begin
      spark_upd = spark_cnt_q + 1'b1;
    end
    elapsed_inc = {1'b0, elapsed_q} + 1'b1;
    close_int   = in_i.ms_tick && (elapsed_inc > {1'b0, interval_q});

    spark_cnt_d = spark_upd;
    elapsed_d   = elapsed_q;
    if (in_i.ms_tick) begin
      if (close_int) begin
        spark_cnt_d = '0;
        elapsed_d   = '0;
      end else begin
        elapsed_d = elapsed_inc[RPM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spark_cnt_q <= '0;
      elapsed_q   <= '0;
      prod_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        spark_cnt_q <= spark_cnt_d;
        elapsed_q   <= elapsed_d;
      end
      if (in_acc && close_int) begin
        prod_vld_q <= 1'b1;
      end else if (prod_move) begin
        prod_vld_q <= 1'b0;
      end
    end
  end

  // Product register, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && close_int) begin
      prod_q <= PROD_W'(spark_upd) * PROD_W'(scale_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: saturate, average, compare
  // ---------------------------------------------------------------------------
  logic [RPM_W-1:0] rpm_raw;
  logic [RPM_W:0]   rpm_sum;
  logic [RPM_W-1:0] rpm_avg;
  logic             limit_hit;
  logic [LED_N-1:0] pattern;
  logic [RPM_W-1:0] prev_rpm_q;
  logic             blink_q;

  logic [LED_N-1:0] led_q;
  logic [RPM_W-1:0] avg_q;
  logic             limit_q;

  always_comb begin
    rpm_raw   = (|prod_q[PROD_W-1:RPM_W]) ? {RPM_W{1'b1}} : prod_q[RPM_W-1:0];
    rpm_sum   = {1'b0, rpm_raw} + {1'b0, prev_rpm_q};
    rpm_avg   = rpm_sum[RPM_W:1];
    limit_hit = rpm_avg > limit_thr_q;
    for (int i = 0; i < LED_N; i++) begin
      pattern[i] = rpm_avg > led_thr_q[i];
    end
    if (limit_hit) begin
      pattern = blink_q ? '0 : {LED_N{1'b1}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_rpm_q <= '0;
      blink_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (prod_move) begin
        prev_rpm_q <= rpm_raw;
        if (limit_hit) begin
          blink_q <= !blink_q;
        end
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    if (prod_move) begin
      led_q   <= pattern;
      avg_q   <= rpm_avg;
      limit_q <= limit_hit;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.led_pattern    = led_q;
  assign out_o.rpm_averaged   = avg_q;
  assign out_o.limiter_active = limit_q;

endmodule

`default_nettype wire

FILE: rtl/tsl_checker.sv
// Port-level checks for the tachometer shift light, bound to the top level.
`default_nettype none

module tsl_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         in_tick,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [tsl_pkg::LED_N-1:0]    out_led,
  input wire [tsl_pkg::RPM_W-1:0]    out_avg,
  input wire                         out_limit
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_led) && $stable(out_avg)
      && $stable(out_limit))
    else $error("stalled result transaction changed");

  // Limiter blink drives all LEDs together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_limit |-> (out_led == '0) || (out_led == '1))
    else $error("limiter active but LEDs not all equal");

  // Input stalls only when both result slots are full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // A fresh result follows an accepted tick through the product and output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_tick, 2))
    else $error("result transaction without a preceding tick");

endmodule

bind tachometer_shift_light_top tsl_checker u_tsl_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_tick   (in_i.ms_tick),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_led   (out_o.led_pattern),
  .out_avg   (out_o.rpm_averaged),
  .out_limit (out_o.limiter_active)
);

`default_nettype wire

FILE: bench/tachometer_shift_light_top_tb.sv
// Self-checking bench for the tachometer shift light: predicted bar graph results versus out_o.
`timescale 1ns / 1ps

module tachometer_shift_light_top_tb;

  localparam int unsigned LED_N      = tsl_pkg::LED_N;
  localparam int unsigned RPM_W      = tsl_pkg::RPM_W;
  localparam int unsigned SCALE_W    = tsl_pkg::SCALE_W;
  localparam int unsigned CFG_IDX_W  = tsl_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = tsl_pkg::CFG_DATA_W;

  // Bench sizing. A result leaves through the product and output registers after the closing
  // transaction, so a short pad after the last result covers anything still in flight.
  localparam int unsigned SPARK_BITS   = tsl_pkg::SPARK_COUNT_BITS_DFLT;
  localparam int unsigned PROD_BITS    = SPARK_BITS + SCALE_W;
  localparam int unsigned DRAIN_PAD    = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned RANDOM_CLOSE = 10;
  localparam logic [SPARK_BITS-1:0] SPARK_MAX = '1;
  // Index past the end of the register list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct packed {
    logic tick;
    logic spark;
  } flags_t;

  typedef struct packed {
    logic [LED_N-1:0] leds;
    logic [RPM_W-1:0] avg;
    logic             limiter;
  } bar_result_t;

  // Receiver back-pressure styles, switched at random.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  tsl_in_if  in_if ();
  tsl_out_if out_if ();
  tsl_cfg_if cfg_if ();

  tachometer_shift_light_top #(
    .SPARK_COUNT_BITS(SPARK_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Predictor copy of the configuration registers.
  logic [SCALE_W-1:0] scale_reg;
  logic [RPM_W-1:0]   interval_reg;
  logic [RPM_W-1:0]   led_thr [LED_N];
  logic [RPM_W-1:0]   limiter_thr;

  // Predictor copy of the block state.
  logic [SPARK_BITS-1:0] spark_cnt;
  logic [RPM_W-1:0]      elapsed_ms;
  logic [RPM_W-1:0]      prev_rpm;
  logic                  blink_phase;

  flags_t      flag_q[$];        // transactions still to be offered
  bar_result_t bar_expect_q[$];  // predicted results awaiting out_o

  int unsigned err_cnt        = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned pushed_items   = 0;
  int unsigned closes_queued  = 0;

  // Sender pacing
  bit          in_taken   = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Receiver pacing
  rx_mode_e    rx_mode  = RX_OPEN;
  int unsigned rx_span  = 0;
  bit          holding  = 1'b0;
  event        hold_evt;

  // ---------------------------------------------------------------------------
  // Clock and cycle guard
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A stuck handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_predictor();
    scale_reg    = tsl_pkg::RST_RPM_PER_SPARK;
    interval_reg = tsl_pkg::RST_UPDATE_INTERVAL;
    led_thr[0]   = tsl_pkg::RST_LED0_THRESHOLD;
    led_thr[1]   = tsl_pkg::RST_LED1_THRESHOLD;
    led_thr[2]   = tsl_pkg::RST_LED2_THRESHOLD;
    led_thr[3]   = tsl_pkg::RST_LED3_THRESHOLD;
    limiter_thr  = tsl_pkg::RST_LIMITER_THRESH;
    spark_cnt    = '0;
    elapsed_ms   = '0;
    prev_rpm     = '0;
    blink_phase  = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      tsl_pkg::CFG_RPM_PER_SPARK:   scale_reg    = val[SCALE_W-1:0];
      tsl_pkg::CFG_UPDATE_INTERVAL: interval_reg = val;
      tsl_pkg::CFG_LED0_THRESHOLD:  led_thr[0]   = val;
      tsl_pkg::CFG_LED1_THRESHOLD:  led_thr[1]   = val;
      tsl_pkg::CFG_LED2_THRESHOLD:  led_thr[2]   = val;
      tsl_pkg::CFG_LED3_THRESHOLD:  led_thr[3]   = val;
      tsl_pkg::CFG_LIMITER_THRESH:  limiter_thr  = val;
      default: ;
    endcase
  endfunction

  // One accepted transaction: count the spark first (it belongs to the interval
  // that may close now), then let a tick advance or close the interval.
  function automatic void step_bar_graph(logic tick, logic spark);
    logic [RPM_W:0]              next_ms;
    logic [PROD_BITS-1:0]        product;
    logic [RPM_W-1:0]            raw_rpm;
    logic [RPM_W:0]              rpm_sum;
    bar_result_t                 res;
    if (spark && spark_cnt != SPARK_MAX)
      spark_cnt = spark_cnt + 1'b1;
    if (tick) begin
      next_ms = {1'b0, elapsed_ms} + 1'b1;
      if (next_ms <= {1'b0, interval_reg}) begin
        elapsed_ms = next_ms[RPM_W-1:0];
      end else begin
        product = PROD_BITS'(spark_cnt) * PROD_BITS'(scale_reg);
        raw_rpm = (product > {RPM_W{1'b1}}) ? {RPM_W{1'b1}} : product[RPM_W-1:0];
        rpm_sum = {1'b0, raw_rpm} + {1'b0, prev_rpm};
        res.avg     = rpm_sum[RPM_W:1];
        res.leds    = '0;
        res.limiter = 1'b0;
        if (res.avg > limiter_thr) begin
          // limiter blink: thresholds ignored, all LEDs follow the phase
          res.limiter = 1'b1;
          res.leds    = blink_phase ? '0 : '1;
          blink_phase = ~blink_phase;
        end else begin
          for (int i = 0; i < LED_N; i++)
            if (res.avg > led_thr[i]) res.leds[i] = 1'b1;
        end
        spark_cnt  = '0;
        elapsed_ms = '0;
        prev_rpm   = raw_rpm;
        bar_expect_q.push_back(res);
      end
    end
  endfunction

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps, offer held until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      // hold idle through reset
    end else if (in_if.valid && !in_taken) begin
      // transaction still on offer, keep it stable
    end else if (gap_left != 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else if (flag_q.size() != 0) begin
      in_if.valid      <= 1'b1;
      in_if.ms_tick    <= flag_q[0].tick;
      in_if.spark_fire <= flag_q[0].spark;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 60);
        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Input acceptance feeds the predictor straight from the wires.
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_if.valid && in_if.ready;
    if (in_taken) begin
      void'(flag_q.pop_front());
      step_bar_graph(in_if.ms_tick, in_if.spark_fire);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own plus the long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(hold_evt);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      holding = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    logic rdy;
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = $urandom_range(16, 128);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      RX_OPEN:   rdy = 1'b1;
      RX_COIN:   rdy = 1'($urandom_range(0, 1));
      RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
      default:   rdy = ($urandom_range(0, 9) != 0);
    endcase
    out_if.ready <= rdy && !holding;
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bar_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (bar_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected result leds=%h avg=%0d lim=%b",
                             out_if.led_pattern, out_if.rpm_averaged, out_if.limiter_active));
      end else begin
        exp_r = bar_expect_q.pop_front();
        if (out_if.led_pattern !== exp_r.leds || out_if.rpm_averaged !== exp_r.avg ||
            out_if.limiter_active !== exp_r.limiter)
          flag_error($sformatf(
            "result mismatch: leds %h/%h avg %0d/%0d lim %b/%b (expected/actual)",
            exp_r.leds, out_if.led_pattern, exp_r.avg, out_if.rpm_averaged,
            exp_r.limiter, out_if.limiter_active));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(bit tick, bit spark);
    flag_q.push_back('{tick: tick, spark: spark});
    pushed_items++;
  endtask

  // A well-formed interval: sparks scattered among the ticks, the last tick
  // closing it (possibly with a spark in the same transaction, else the last spark may follow).
  task automatic push_interval(int unsigned ticks, int unsigned sparks);
    bit t;
    bit s;
    while (ticks != 0 || sparks != 0) begin
      t = (ticks > 1 || (ticks == 1 && sparks <= 1)) && ($urandom_range(0, 3) == 0);
      s = (sparks != 0) && ($urandom_range(0, 1) == 0);
      push_item(t, s);
      if (t) ticks--;
      if (s) sparks--;
    end
    closes_queued++;
  endtask

  // Configuration writes: valid stays up across back-to-back writes and is
  // lowered once at the end.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, val);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_bar(logic [CFG_DATA_W-1:0] scale, logic [RPM_W-1:0] interval,
                             logic [RPM_W-1:0] t0, logic [RPM_W-1:0] t1,
                             logic [RPM_W-1:0] t2, logic [RPM_W-1:0] t3,
                             logic [RPM_W-1:0] lim);
    write_reg(tsl_pkg::CFG_RPM_PER_SPARK,   scale);
    write_reg(tsl_pkg::CFG_UPDATE_INTERVAL, interval);
    write_reg(tsl_pkg::CFG_LED0_THRESHOLD,  t0);
    write_reg(tsl_pkg::CFG_LED1_THRESHOLD,  t1);
    write_reg(tsl_pkg::CFG_LED2_THRESHOLD,  t2);
    write_reg(tsl_pkg::CFG_LED3_THRESHOLD,  t3);
    write_reg(tsl_pkg::CFG_LIMITER_THRESH,  lim);
    end_writes();
  endtask

  // Sender stops until every predicted result is back, then a short pad.
  task automatic drain_block();
    do @(posedge clk_i);
    while (flag_q.size() != 0 || in_if.valid || bar_expect_q.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  function automatic logic [RPM_W-1:0] pick_threshold(int unsigned span);
    return ($urandom_range(0, 3) == 0) ? RPM_W'($urandom_range(0, 65535))
                                       : RPM_W'($urandom_range(0, span));
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned item_floor;
    int unsigned close_floor;
    int unsigned span;
    logic [SCALE_W-1:0] scale;
    logic [RPM_W-1:0]   interval;

    // every input known from time zero
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.ms_tick    = 1'b0;
    in_if.spark_fire = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    reset_predictor();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values untouched: one default interval closing on its 201st tick,
    // 76 sparks landing the average above every LED threshold but below the
    // limiter; the closing transaction carries a spark.
    for (int i = 0; i < 201; i++) push_item(1'b1, (i % 8) < 3);
    closes_queued++;
    drain_block();

    // Directed: largest scale, every tick closes, spread LED thresholds.
    program_bar(16'd1023, 16'd0, 16'd0, 16'd1023, 16'd2046, 16'hFFFF, 16'hFFFF);
    push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b0);   // close with no sparks
    push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b1);   // spark in the closing transaction counts
    push_item(1'b1, 1'b1);
    push_item(1'b0, 1'b1);
    push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b0);
    drain_block();

    // Directed: low limiter, blink phase alternates across updates.
    write_reg(tsl_pkg::CFG_LIMITER_THRESH, 16'd1000);
    end_writes();
    repeat (5) push_item(1'b1, 1'b1);
    push_item(1'b1, 1'b0);
    drain_block();

    // Directed: scale masked down to zero, unused index ignored.
    write_reg(tsl_pkg::CFG_RPM_PER_SPARK, 16'hFC00);
    write_reg(CFG_IDX_UNUSED,             16'hFFFF);
    end_writes();
    push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b1);
    push_item(1'b1, 1'b0);
    drain_block();

    // Directed: interval lowered beneath the elapsed count closes on next tick.
    program_bar(16'd1, 16'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (8) push_item(1'b1, 1'b0);
    drain_block();
    write_reg(tsl_pkg::CFG_UPDATE_INTERVAL, 16'd3);
    end_writes();
    push_item(1'b1, 1'b1);
    drain_block();

    // Raw rpm overflow: 70 sparks at the largest scale saturate to 65535,
    // then an empty interval averages that with zero.
    program_bar(16'd1023, 16'd0, 16'd0, 16'd30000, 16'd60000, 16'd65534, 16'hFFFF);
    repeat (69) push_item(1'b0, 1'b1);
    push_item(1'b1, 1'b1);
    push_item(1'b1, 1'b0);
    drain_block();

    // Long receiver hold-off while the sender keeps offering: every tick
    // closes, so the result path fills and input back-pressure must appear.
    program_bar(16'd200, 16'd0, 16'd100, 16'd300, 16'd500, 16'd700, 16'd900);
    repeat (60) push_item(1'b1, 1'($urandom_range(0, 1)));
    @(posedge clk_i);
    -> hold_evt;
    drain_block();

    // Random phases: fresh settings each phase, mostly whole intervals with
    // random spark counts, some noise between them.
    item_floor  = pushed_items + RANDOM_ITEMS;
    close_floor = closes_queued + RANDOM_CLOSE;
    while (pushed_items < item_floor || closes_queued < close_floor) begin
      scale    = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom_range(1, 60))
                                             : SCALE_W'($urandom_range(1, 1023));
      interval = ($urandom_range(0, 7) == 0) ? RPM_W'($urandom_range(9, 40))
                                             : RPM_W'($urandom_range(0, 8));
      span     = scale * 40;
      if (span > 65535) span = 65535;
      program_bar(CFG_DATA_W'(scale), interval, pick_threshold(span), pick_threshold(span),
                  pick_threshold(span), pick_threshold(span), pick_threshold(span));
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(3, 15))
            push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        push_interval(interval + 1, $urandom_range(0, 40));
      end
      drain_block();
    end

    if (err_cnt == 0 && bar_expect_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
